// File: src/whsl_pkg.sv
// Shared types and constants for the wheel speed limiter.
`default_nettype none

package whsl_pkg;

    localparam int CfgW   = 31;   // width of every limit register
    localparam int SpdW   = 32;   // signed Q16.16 speed
    localparam int DtW    = 24;   // unsigned Q0.24 time step
    localparam int IdxW   = 3;    // register index
    localparam int FracW  = 16;   // fraction bits of Q16.16
    localparam int QuoW   = CfgW + FracW;  // quotient bits of the ratio divider
    localparam int InW    = 3 * SpdW + DtW;
    localparam int OutW   = 2 * SpdW;

    localparam logic [SpdW-1:0] RatioOne = 32'h0001_0000;
    localparam logic [SpdW-1:0] IntMax   = 32'h7FFF_FFFF;
    localparam logic [SpdW-1:0] IntMin   = 32'h8000_0000;
    localparam logic [CfgW-1:0] CfgFull  = 31'h7FFF_FFFF;

    typedef enum logic [IdxW-1:0] {
        REG_MIN_SPEED = 3'd0,
        REG_MAX_SPEED = 3'd1,
        REG_MIN_ACCEL = 3'd2,
        REG_MAX_ACCEL = 3'd3,
        REG_MIN_DECEL = 3'd4,
        REG_MAX_DECEL = 3'd5,
        REG_JERK_LO   = 3'd6,
        REG_JERK_HI   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [CfgW-1:0] min_speed;
        logic [CfgW-1:0] max_speed;
        logic [CfgW-1:0] min_accel;
        logic [CfgW-1:0] max_accel;
        logic [CfgW-1:0] min_decel;
        logic [CfgW-1:0] max_decel;
        logic [CfgW-1:0] jerk_lo;
        logic [CfgW-1:0] jerk_hi;
    } t_cfg;

    typedef struct packed {
        logic [SpdW-1:0] lo;
        logic [SpdW-1:0] hi;
    } t_jerk_bnd;

    typedef struct packed {
        logic [CfgW-1:0] acc_lo;
        logic [CfgW-1:0] acc_hi;
        logic [CfgW-1:0] dec_lo;
        logic [CfgW-1:0] dec_hi;
    } t_acc_bnd;

endpackage

`default_nettype wire

// File: src/whsl_bnd.sv
// Band bounds scaled by the time step: jerk*dt^2 and accel*dt.
`default_nettype none

module whsl_bnd (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire whsl_pkg::t_cfg                 i_cfg,
    input  wire logic [whsl_pkg::DtW-1:0]       i_dt,
    output whsl_pkg::t_jerk_bnd                 o_jerk,   // valid with stage 2
    output whsl_pkg::t_acc_bnd                  o_acc     // valid with stage 3
);

    localparam int PW = whsl_pkg::CfgW + whsl_pkg::DtW;

    logic [PW-1:0]            r_pj_lo, r_pj_hi;
    logic [PW-1:0]            r_pa_lo, r_pa_hi, r_pd_lo, r_pd_hi;
    logic [whsl_pkg::DtW-1:0] r_dt1;
    whsl_pkg::t_acc_bnd       r_acc2;
    logic [PW-1:0]            n_j2_lo, n_j2_hi;

    // stage 1: one product per bound
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pj_lo <= PW'(i_cfg.jerk_lo)   * PW'(i_dt);
            r_pj_hi <= PW'(i_cfg.jerk_hi)   * PW'(i_dt);
            r_pa_lo <= PW'(i_cfg.min_accel) * PW'(i_dt);
            r_pa_hi <= PW'(i_cfg.max_accel) * PW'(i_dt);
            r_pd_lo <= PW'(i_cfg.min_decel) * PW'(i_dt);
            r_pd_hi <= PW'(i_cfg.max_decel) * PW'(i_dt);
            r_dt1   <= i_dt;
        end
    end

    // jerk needs the second dt factor
    always_comb begin
        n_j2_lo = PW'(r_pj_lo[PW-1:whsl_pkg::DtW]) * PW'(r_dt1);
        n_j2_hi = PW'(r_pj_hi[PW-1:whsl_pkg::DtW]) * PW'(r_dt1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_jerk.lo     <= n_j2_lo[PW-1:whsl_pkg::DtW-1];
            o_jerk.hi     <= n_j2_hi[PW-1:whsl_pkg::DtW-1];
            r_acc2.acc_lo <= r_pa_lo[PW-1:whsl_pkg::DtW];
            r_acc2.acc_hi <= r_pa_hi[PW-1:whsl_pkg::DtW];
            r_acc2.dec_lo <= r_pd_lo[PW-1:whsl_pkg::DtW];
            r_acc2.dec_hi <= r_pd_hi[PW-1:whsl_pkg::DtW];
            o_acc         <= r_acc2;
        end
    end

endmodule

`default_nettype wire

// File: src/whsl_lim.sv
// Jerk, acceleration and velocity limit stages.
`default_nettype none

module whsl_lim (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire logic                               i_vld,
    input  wire logic signed [whsl_pkg::SpdW-1:0]   i_req,
    input  wire logic signed [whsl_pkg::SpdW-1:0]   i_prev,
    input  wire logic signed [whsl_pkg::SpdW-1:0]   i_older,
    input  wire whsl_pkg::t_jerk_bnd                i_jerk,
    input  wire whsl_pkg::t_acc_bnd                 i_acc,
    input  wire logic [whsl_pkg::CfgW-1:0]          i_min_speed,
    input  wire logic [whsl_pkg::CfgW-1:0]          i_max_speed,
    output logic                                    o_vld,
    output logic signed [whsl_pkg::SpdW-1:0]        o_speed,
    output logic signed [whsl_pkg::SpdW-1:0]        o_req
);

    function automatic logic [35:0] f_band(input logic [35:0] m, input logic [35:0] lo,
                                           input logic [35:0] hi);
        logic [35:0] r;
        r = (m < lo) ? lo : m;
        return (r > hi) ? hi : r;
    endfunction

    logic               r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    logic signed [34:0] r_s1_d, r_s2_d;
    logic signed [33:0] r_s1_pred, r_s2_pred;
    logic signed [31:0] r_s1_v0, r_s2_v0, r_s3_v0;
    logic signed [31:0] r_s1_req, r_s2_req, r_s3_req, r_s4_req;
    logic signed [34:0] r_s3_v;
    logic signed [32:0] r_s4_v;

    logic [34:0]        n_s3_dmag;
    logic [35:0]        n_s3_m;
    logic signed [34:0] n_s3_v;
    logic [34:0]        n_s4_vmag;
    logic [32:0]        n_s4_v0mag;
    logic signed [35:0] n_s4_e;
    logic [35:0]        n_s4_emag, n_s4_lo, n_s4_hi, n_s4_m;
    logic signed [32:0] n_s4_v;
    logic [32:0]        n_s5_vmag;
    logic [35:0]        n_s5_m;
    logic signed [31:0] n_s5_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            o_vld    <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            o_vld    <= r_s4_vld;
        end
    end

    // stages 1 and 2: second difference and the extrapolated speed, then a delay
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_d    <= 35'(i_req) - (35'(i_prev) <<< 1) + 35'(i_older);
            r_s1_pred <= (34'(i_prev) <<< 1) - 34'(i_older);
            r_s1_v0   <= i_prev;
            r_s1_req  <= i_req;
            r_s2_d    <= r_s1_d;
            r_s2_pred <= r_s1_pred;
            r_s2_v0   <= r_s1_v0;
            r_s2_req  <= r_s1_req;
        end
    end

    // stage 3: jerk band, sign of the second difference kept
    always_comb begin
        n_s3_dmag = r_s2_d[34] ? 35'(-r_s2_d) : 35'(r_s2_d);
        n_s3_m    = f_band(36'(n_s3_dmag), 36'(i_jerk.lo), 36'(i_jerk.hi));
        n_s3_v    = 35'(r_s2_pred) + (r_s2_d[34] ? -$signed(n_s3_m[34:0])
                                                 : $signed(n_s3_m[34:0]));
    end

    // stage 4: accel band while speed grows, decel band while it shrinks
    always_comb begin
        n_s4_vmag  = r_s3_v[34] ? 35'(-r_s3_v) : 35'(r_s3_v);
        n_s4_v0mag = r_s3_v0[31] ? 33'(-33'(r_s3_v0)) : 33'(r_s3_v0);
        if (n_s4_vmag >= 35'(n_s4_v0mag)) begin
            n_s4_lo = 36'(i_acc.acc_lo);
            n_s4_hi = 36'(i_acc.acc_hi);
        end else begin
            n_s4_lo = 36'(i_acc.dec_lo);
            n_s4_hi = 36'(i_acc.dec_hi);
        end
        n_s4_e    = 36'(r_s3_v) - 36'(r_s3_v0);
        n_s4_emag = n_s4_e[35] ? 36'(-n_s4_e) : 36'(n_s4_e);
        n_s4_m    = f_band(n_s4_emag, n_s4_lo, n_s4_hi);
        n_s4_v    = 33'(r_s3_v0) + (n_s4_e[35] ? -$signed({2'b00, n_s4_m[30:0]})
                                               : $signed({2'b00, n_s4_m[30:0]}));
    end

    // stage 5: velocity band, zero counts as positive
    always_comb begin
        n_s5_vmag = r_s4_v[32] ? 33'(-r_s4_v) : 33'(r_s4_v);
        n_s5_m    = f_band(36'(n_s5_vmag), 36'(i_min_speed), 36'(i_max_speed));
        n_s5_v    = r_s4_v[32] ? -$signed({1'b0, n_s5_m[30:0]})
                               : $signed({1'b0, n_s5_m[30:0]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_v   <= n_s3_v;
            r_s3_v0  <= r_s2_v0;
            r_s3_req <= r_s2_req;
            r_s4_v   <= n_s4_v;
            r_s4_req <= r_s3_req;
            o_speed  <= n_s5_v;
            o_req    <= r_s4_req;
        end
    end

`ifndef NO_ASSERTIONS
    // the velocity band never reaches the most negative code
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> o_speed != $signed(whsl_pkg::IntMin))
        else $error("limited speed out of band");
`endif

endmodule

`default_nettype wire

// File: src/whsl_div.sv
// Pipelined restoring divider for the limited-to-requested ratio.
`default_nettype none

module whsl_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire logic                               i_vld,
    input  wire logic signed [whsl_pkg::SpdW-1:0]   i_speed,
    input  wire logic signed [whsl_pkg::SpdW-1:0]   i_req,
    output logic                                    o_vld,
    output logic [whsl_pkg::SpdW-1:0]               o_speed,
    output logic [whsl_pkg::SpdW-1:0]               o_ratio
);

    localparam int QW = whsl_pkg::QuoW;
    localparam int SW = whsl_pkg::SpdW;

    logic          r_vld  [0:QW];
    logic [SW-1:0] r_rem  [0:QW];
    logic [QW-1:0] r_num  [0:QW];
    logic [QW-1:0] r_quo  [0:QW];
    logic [SW-1:0] r_den  [0:QW];
    logic          r_neg  [0:QW];
    logic          r_zero [0:QW];
    logic [SW-1:0] r_spd  [0:QW];

    logic [SW-1:0] n_smag, n_rmag, n_ratio;

    // stage 0: load magnitudes
    always_comb begin
        n_smag = i_speed[SW-1] ? SW'(-i_speed) : SW'(i_speed);
        n_rmag = i_req[SW-1] ? SW'(-i_req) : SW'(i_req);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_num[0]  <= {n_smag[whsl_pkg::CfgW-1:0], {whsl_pkg::FracW{1'b0}}};
            r_quo[0]  <= '0;
            r_den[0]  <= n_rmag;
            r_neg[0]  <= i_speed[SW-1] != i_req[SW-1];
            r_zero[0] <= i_req == '0;
            r_spd[0]  <= i_speed;
        end
    end

    // one quotient bit per stage
    for (genvar s = 1; s <= QW; s++) begin : g_stage
        logic [SW:0]   n_t;
        logic          n_ge;
        logic [SW-1:0] n_rem;

        always_comb begin
            n_t   = {r_rem[s-1], r_num[s-1][QW-1]};
            n_ge  = n_t >= {1'b0, r_den[s-1]};
            n_rem = n_ge ? SW'(n_t - {1'b0, r_den[s-1]}) : n_t[SW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_num[s]  <= {r_num[s-1][QW-2:0], 1'b0};
                r_quo[s]  <= {r_quo[s-1][QW-2:0], n_ge};
                r_den[s]  <= r_den[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_zero[s] <= r_zero[s-1];
                r_spd[s]  <= r_spd[s-1];
            end
        end
    end

    // ratio of one for a zero request, else saturate to the signed 32-bit range
    always_comb begin
        if (r_zero[QW]) begin
            n_ratio = whsl_pkg::RatioOne;
        end else if (r_neg[QW]) begin
            n_ratio = (r_quo[QW] > QW'(whsl_pkg::IntMin)) ? whsl_pkg::IntMin
                                                          : SW'(-r_quo[QW]);
        end else begin
            n_ratio = (r_quo[QW] > QW'(whsl_pkg::IntMax)) ? whsl_pkg::IntMax
                                                          : r_quo[QW][SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= r_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_speed <= r_spd[QW];
            o_ratio <= n_ratio;
        end
    end

`ifndef NO_ASSERTIONS
    // partial remainder stays below the divisor
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[QW] && r_den[QW] != '0) |-> r_rem[QW] < r_den[QW])
        else $error("divider remainder not reduced");
`endif

endmodule

`default_nettype wire

// File: src/wheel_speed_jerk_accel_limiter_unit.sv
// Wheel speed limiter top level: stream ports, limit registers and pipeline.
//
// Slave stream carries one command per beat: requested speed, the two last
// commanded speeds and the time step. Master stream returns one beat per
// command with the limited speed and its ratio to the request.
// Limit registers are written through i_cfg_we/i_cfg_idx/i_cfg_data, one
// register per cycle; the user must write them only while the pipeline
// holds no command; the block does not enforce this. From the slave beat
// to the master beat a command passes five stages of bound products and
// jerk, acceleration and velocity limits, one load stage and 47 stages of
// the ratio divider (one quotient bit per stage), and the output register.
// Throughput is one command per cycle unless the receiver stalls; the whole
// pipeline advances together. When the receiver stalls with a beat on the
// output, every stage holds and o_s_tready drops; nothing is lost or repeated.
// Synchronous reset clears all valid bits and sets every limit register to
// its open band (lower bounds 0, upper bounds all ones).
`default_nettype none

module wheel_speed_jerk_accel_limiter_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // requested_speed, previous_speed, older_speed, time_step
    input  wire logic [whsl_pkg::InW-1:0]       i_s_tdata,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // limited_speed, scale_ratio
    output logic [whsl_pkg::OutW-1:0]           o_m_tdata,
    input  wire logic                           i_cfg_we,
    input  wire logic [whsl_pkg::IdxW-1:0]      i_cfg_idx,
    input  wire logic [whsl_pkg::CfgW-1:0]      i_cfg_data
);

    localparam int SW = whsl_pkg::SpdW;

    whsl_pkg::t_cfg      r_cfg;
    whsl_pkg::t_jerk_bnd jerk;
    whsl_pkg::t_acc_bnd  acc;
    logic                en;
    logic                lim_vld;
    logic signed [SW-1:0] lim_speed, lim_req;
    logic [SW-1:0]       out_speed, out_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_speed <= '0;
            r_cfg.max_speed <= whsl_pkg::CfgFull;
            r_cfg.min_accel <= '0;
            r_cfg.max_accel <= whsl_pkg::CfgFull;
            r_cfg.min_decel <= '0;
            r_cfg.max_decel <= whsl_pkg::CfgFull;
            r_cfg.jerk_lo   <= '0;
            r_cfg.jerk_hi   <= whsl_pkg::CfgFull;
        end else if (i_cfg_we) begin
            case (whsl_pkg::t_reg_idx'(i_cfg_idx))
                whsl_pkg::REG_MIN_SPEED: r_cfg.min_speed <= i_cfg_data;
                whsl_pkg::REG_MAX_SPEED: r_cfg.max_speed <= i_cfg_data;
                whsl_pkg::REG_MIN_ACCEL: r_cfg.min_accel <= i_cfg_data;
                whsl_pkg::REG_MAX_ACCEL: r_cfg.max_accel <= i_cfg_data;
                whsl_pkg::REG_MIN_DECEL: r_cfg.min_decel <= i_cfg_data;
                whsl_pkg::REG_MAX_DECEL: r_cfg.max_decel <= i_cfg_data;
                whsl_pkg::REG_JERK_LO:   r_cfg.jerk_lo   <= i_cfg_data;
                whsl_pkg::REG_JERK_HI:   r_cfg.jerk_hi   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance while the output register is empty or being taken
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    whsl_bnd u_bnd (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_cfg  (r_cfg),
        .i_dt   (i_s_tdata[3*SW +: whsl_pkg::DtW]),
        .o_jerk (jerk),
        .o_acc  (acc)
    );

    whsl_lim u_lim (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_vld       (i_s_tvalid),
        .i_req       ($signed(i_s_tdata[0 +: SW])),
        .i_prev      ($signed(i_s_tdata[SW +: SW])),
        .i_older     ($signed(i_s_tdata[2*SW +: SW])),
        .i_jerk      (jerk),
        .i_acc       (acc),
        .i_min_speed (r_cfg.min_speed),
        .i_max_speed (r_cfg.max_speed),
        .o_vld       (lim_vld),
        .o_speed     (lim_speed),
        .o_req       (lim_req)
    );

    whsl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (lim_vld),
        .i_speed (lim_speed),
        .i_req   (lim_req),
        .o_vld   (o_m_tvalid),
        .o_speed (out_speed),
        .o_ratio (out_ratio)
    );

    assign o_m_tdata = {out_ratio, out_speed};

`ifndef NO_ASSERTIONS
    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

// File: test/wheel_speed_jerk_accel_limiter_unit_tb.sv
// Wheel speed limiter testbench: directed and random commands checked by a local predictor.
`default_nettype none

module wheel_speed_jerk_accel_limiter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [whsl_pkg::DtW-1:0]  time_step;
        logic [whsl_pkg::SpdW-1:0] older_speed;
        logic [whsl_pkg::SpdW-1:0] previous_speed;
        logic [whsl_pkg::SpdW-1:0] requested_speed;
    } t_cmd;

    typedef struct packed {
        logic [whsl_pkg::SpdW-1:0] scale_ratio;
        logic [whsl_pkg::SpdW-1:0] limited_speed;
    } t_res;

    localparam int Latency = 54;
    localparam longint CycleLimit = 400000;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_s_tvalid = 1'b0;
    logic                         o_s_tready;
    logic [whsl_pkg::InW-1:0]     i_s_tdata = '0;
    logic                         o_m_tvalid;
    logic                         i_m_tready = 1'b0;
    logic [whsl_pkg::OutW-1:0]    o_m_tdata;
    logic                         i_cfg_we = 1'b0;
    logic [whsl_pkg::IdxW-1:0]    i_cfg_idx = '0;
    logic [whsl_pkg::CfgW-1:0]    i_cfg_data = '0;

    wheel_speed_jerk_accel_limiter_unit dut (.*);

    logic [whsl_pkg::CfgW-1:0] limits [8];
    t_cmd   pending_cmds [$];
    t_res   expected_res [$];
    int     fail_count = 0;
    longint cycle_count = 0;
    bit     tx_gaps = 1'b1;
    bit     rx_gaps = 1'b1;
    int     rx_hold = 0;
    int     tx_gap = 0;
    int     rx_gap = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned magnitude(longint x);
        return x < 0 ? longint'(-x) : longint'(x);
    endfunction

    function automatic longint unsigned clamp(longint unsigned m, longint unsigned lo,
                                              longint unsigned hi);
        if (m < lo) m = lo;
        if (m > hi) m = hi;
        return m;
    endfunction

    function automatic longint unsigned jerk_band(logic [whsl_pkg::CfgW-1:0] j,
                                                  longint unsigned dt);
        longint unsigned t;
        t = (longint'(j) * dt) >> 24;
        return (t * dt) >> 23;
    endfunction

    function automatic longint unsigned accel_band(logic [whsl_pkg::CfgW-1:0] a,
                                                   longint unsigned dt);
        return (longint'(a) * dt) >> 24;
    endfunction

    function automatic t_res limit_speed(t_cmd c);
        longint req, v0, v1, v, d, e, ratio;
        longint unsigned m, lo, hi, dt, q;
        t_res r;
        req = longint'($signed(c.requested_speed));
        v0  = longint'($signed(c.previous_speed));
        v1  = longint'($signed(c.older_speed));
        dt  = c.time_step;
        // jerk
        d = (req - v0) - (v0 - v1);
        m = clamp(magnitude(d), jerk_band(limits[whsl_pkg::REG_JERK_LO], dt),
                  jerk_band(limits[whsl_pkg::REG_JERK_HI], dt));
        v = 2 * v0 - v1 + (d >= 0 ? longint'(m) : -longint'(m));
        // acceleration or deceleration depending on growth of magnitude
        if (magnitude(v) >= magnitude(v0)) begin
            lo = accel_band(limits[whsl_pkg::REG_MIN_ACCEL], dt);
            hi = accel_band(limits[whsl_pkg::REG_MAX_ACCEL], dt);
        end else begin
            lo = accel_band(limits[whsl_pkg::REG_MIN_DECEL], dt);
            hi = accel_band(limits[whsl_pkg::REG_MAX_DECEL], dt);
        end
        e = v - v0;
        m = clamp(magnitude(e), lo, hi);
        v = v0 + (e >= 0 ? longint'(m) : -longint'(m));
        // velocity
        m = clamp(magnitude(v), limits[whsl_pkg::REG_MIN_SPEED],
                  limits[whsl_pkg::REG_MAX_SPEED]);
        v = v >= 0 ? longint'(m) : -longint'(m);
        if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) v = -64'sh8000_0000;
        if (req == 0) begin
            ratio = longint'(whsl_pkg::RatioOne);
        end else begin
            q = (magnitude(v) << 16) / magnitude(req);
            if ((v < 0) != (req < 0))
                ratio = q > 64'h8000_0000 ? -64'sh8000_0000 : -longint'(q);
            else
                ratio = q > 64'h7FFF_FFFF ? 64'sh7FFF_FFFF : longint'(q);
        end
        r.limited_speed = v[whsl_pkg::SpdW-1:0];
        r.scale_ratio = ratio[whsl_pkg::SpdW-1:0];
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 2);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_res.push_back(limit_speed(t_cmd'(i_s_tdata)));
                void'(pending_cmds.pop_front());
            end
            if (tx_gap > 0 && !(i_s_tvalid && !o_s_tready)) begin
                tx_gap <= tx_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (i_s_tvalid && !o_s_tready) begin
                i_s_tvalid <= 1'b1;
            end else if (pending_cmds.size() > 0 && (!i_s_tvalid || pending_cmds.size() > 0)) begin
                if (tx_gaps && (i_s_tvalid && o_s_tready) && $urandom_range(0, 3) == 0) begin
                    i_s_tvalid <= 1'b0;
                    tx_gap <= gap_len();
                end else begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= pending_cmds[0];
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        t_res got, exp_r;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_res'(o_m_tdata);
            if (expected_res.size() == 0) begin
                $error("unexpected result beat %h", o_m_tdata);
                fail_count++;
            end else begin
                exp_r = expected_res.pop_front();
                if (got.limited_speed !== exp_r.limited_speed) begin
                    $error("limited_speed expected %h got %h",
                           exp_r.limited_speed, got.limited_speed);
                    fail_count++;
                end
                if (got.scale_ratio !== exp_r.scale_ratio) begin
                    $error("scale_ratio expected %h got %h",
                           exp_r.scale_ratio, got.scale_ratio);
                    fail_count++;
                end
            end
        end
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            i_m_tready <= 1'b0;
        end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
            rx_gap <= gap_len();
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CycleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_limit(whsl_pkg::t_reg_idx idx, logic [whsl_pkg::CfgW-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        limits[idx] = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || i_s_tvalid || expected_res.size() != 0)
            @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    function automatic logic [whsl_pkg::SpdW-1:0] speed_pick();
        case ($urandom_range(0, 5))
            0: return whsl_pkg::IntMax;
            1: return whsl_pkg::IntMin;
            2: return '0;
            3: return whsl_pkg::SpdW'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        c.requested_speed = speed_pick();
        c.previous_speed = speed_pick();
        // mostly a smooth history so the jerk stage sees realistic steps
        if ($urandom_range(0, 2) != 0)
            c.older_speed = c.previous_speed
                          + whsl_pkg::SpdW'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
        else
            c.older_speed = speed_pick();
        case ($urandom_range(0, 3))
            0: c.time_step = $urandom_range(0, 1) ? '1 : '0;
            1: c.time_step = whsl_pkg::DtW'($urandom_range(0, 1 << 16));
            default: c.time_step = whsl_pkg::DtW'($urandom);
        endcase
        return c;
    endfunction

    function automatic logic [whsl_pkg::CfgW-1:0] limit_pick();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return whsl_pkg::CfgFull;
            2: return whsl_pkg::CfgW'($urandom_range(0, 1 << 20));
            default: return whsl_pkg::CfgW'($urandom);
        endcase
    endfunction

    task automatic random_limits();
        whsl_pkg::t_reg_idx idx;
        for (int i = 0; i < 8; i++) begin
            idx = whsl_pkg::t_reg_idx'(i);
            write_limit(idx, limit_pick());
        end
    endtask

    initial begin
        t_cmd c;
        limits[whsl_pkg::REG_MIN_SPEED] = '0; limits[whsl_pkg::REG_MAX_SPEED] = whsl_pkg::CfgFull;
        limits[whsl_pkg::REG_MIN_ACCEL] = '0; limits[whsl_pkg::REG_MAX_ACCEL] = whsl_pkg::CfgFull;
        limits[whsl_pkg::REG_MIN_DECEL] = '0; limits[whsl_pkg::REG_MAX_DECEL] = whsl_pkg::CfgFull;
        limits[whsl_pkg::REG_JERK_LO]   = '0; limits[whsl_pkg::REG_JERK_HI]   = whsl_pkg::CfgFull;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: open bands, extremes and zero request
        c = '0;
        pending_cmds.push_back(c);
        c.requested_speed = whsl_pkg::IntMax; c.time_step = '1;
        pending_cmds.push_back(c);
        c.requested_speed = whsl_pkg::IntMin; c.previous_speed = whsl_pkg::IntMax;
        c.older_speed = whsl_pkg::IntMin;
        pending_cmds.push_back(c);
        c.requested_speed = 32'h0001_0000; c.previous_speed = '0; c.older_speed = '0;
        pending_cmds.push_back(c);
        drain();

        // tight bands, inverted bands, zero speed with nonzero minimum
        write_limit(whsl_pkg::REG_MIN_SPEED, 31'h0000_8000);
        write_limit(whsl_pkg::REG_MAX_SPEED, 31'h0010_0000);
        write_limit(whsl_pkg::REG_MIN_ACCEL, 31'h0002_0000);
        write_limit(whsl_pkg::REG_MAX_ACCEL, 31'h0001_0000);
        write_limit(whsl_pkg::REG_MIN_DECEL, 31'h0000_4000);
        write_limit(whsl_pkg::REG_MAX_DECEL, 31'h0008_0000);
        write_limit(whsl_pkg::REG_JERK_LO,   31'h0001_0000);
        write_limit(whsl_pkg::REG_JERK_HI,   31'h0100_0000);
        for (int i = 0; i < 16; i++) begin
            c.requested_speed = (i % 4 == 0) ? '0 : speed_pick();
            c.previous_speed = (i % 3 == 0) ? '0 : speed_pick();
            c.older_speed = speed_pick();
            c.time_step = (i % 2) ? '1 : 24'h40_0000;
            pending_cmds.push_back(c);
        end
        drain();

        // random phases, fresh limits after the first; one with long receiver hold-off
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0) begin
                write_limit(whsl_pkg::REG_MIN_SPEED, whsl_pkg::CfgFull);
                write_limit(whsl_pkg::REG_JERK_HI, '0);
            end else begin
                random_limits();
            end
            if (ph == 3) begin
                rx_hold = 300;
                tx_gaps = 1'b0;
            end else begin
                tx_gaps = 1'b1;
            end
            rx_gaps = (ph != 5);
            for (int i = 0; i < 125; i++) pending_cmds.push_back(random_cmd());
            drain();
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
